@@ rtl/tte_pkg.sv @@
// shared types and constants of the tap tempo estimator
package tte_pkg;

	// fixed field widths
	localparam int AVG_BITS       = 23;
	localparam int BPM_BITS       = 16;
	localparam int BEAT_BITS      = 16;
	localparam int CFG_ADDR_BITS  = 2;
	localparam int TEMPO_NUM_BITS = 33;
	localparam int OUT_DATA_BITS  = ((BPM_BITS + 1 + AVG_BITS + BEAT_BITS + 7) / 8) * 8;

	// configuration register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_TOLERANCE = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BLINK     = 2'd1;

	// register reset values
	localparam logic [AVG_BITS-1:0] TOLERANCE_RESET = 23'd100000;
	localparam logic [AVG_BITS-1:0] BLINK_RESET     = 23'd100000;

	// algorithm constants
	localparam logic [AVG_BITS-1:0]       GAP_LIMIT_US  = 23'd5000000;
	localparam logic [AVG_BITS-1:0]       MIN_BLINK_AVG = 23'd1000;
	localparam logic [TEMPO_NUM_BITS-1:0] TEMPO_NUM     = 33'd6000000000;
	localparam logic [BPM_BITS-1:0]       BPM_MAX       = 16'hFFFF;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ELAP,
		S_DECIDE,
		S_DEV,
		S_MUL,
		S_XFER,
		S_DIVA,
		S_TLOAD,
		S_TEMPO,
		S_MOD,
		S_DONE
	} tte_state_t;

	// operation of the shared step unit
	typedef enum logic {
		STEP_MUL,
		STEP_DIV
	} step_op_t;

endpackage

@@ rtl/tap_tempo_estimator.sv @@
// tap tempo estimator top level: sequencer, tempo state and stream ports
//
// Each input transaction is a beat tap (tuser 0) or a time tick (tuser 1)
// with a microsecond timestamp in tdata; each one gives exactly one output
// transaction with tempo (hundredths of bpm), average beat interval, run
// length and the blink indicator. The block works on one transaction at a
// time: all arithmetic runs bit by bit through one shared step unit (a
// shift-add multiplier and restoring divider built on one adder), so the
// item cost is set by that unit. A tap that starts or restarts a run, and a
// tick while the average is below the blink floor, pass through S_ELAP and
// S_DECIDE to the result; a tap that ends a run also passes S_DEV; an
// in-tempo tap runs a COUNT_BITS-step multiply, a 23-step divide for the
// new average and a 33-step divide for the tempo (skipped when the new
// average is zero); a tick runs a TIME_BITS-step modulo. The block returns
// to idle before the next transaction is accepted. The result sits in an
// output register, so a waiting result only stalls the block once the next
// one is ready. Configuration writes are taken at any time and must only be
// issued while the block is idle.
module tap_tempo_estimator import tte_pkg::*; #(
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // time_us
	input  logic                                   s_tuser,   // mode
	// output stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// bpm_hundredths, blink_on, average_us, beat_count
	output logic [OUT_DATA_BITS-1:0]               m_tdata,
	output logic                                   m_tuser,   // bpm_updated
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_ADDR_BITS-1:0]               cfg_addr,
	input  logic [AVG_BITS-1:0]                    cfg_data
);

	// remainder / divisor width covers run + 1 and the average
	localparam int DVW   = (COUNT_BITS + 1 > AVG_BITS) ? COUNT_BITS + 1 : AVG_BITS;
	// shift register holds the widest dividend
	localparam int DW    = (TIME_BITS > TEMPO_NUM_BITS) ? TIME_BITS : TEMPO_NUM_BITS;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int PW    = AVG_BITS + COUNT_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	tte_state_t state_q, state_d;

	// captured transaction
	logic                  mode_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [TIME_BITS-1:0]  elapsed_q;

	// tempo state
	logic [TIME_BITS-1:0]  last_q;
	logic [AVG_BITS-1:0]   avg_q;
	logic [COUNT_BITS-1:0] run_q;
	logic [BPM_BITS-1:0]   tempo_q;
	logic                  blink_q;
	logic                  upd_q;

	// configuration registers
	logic [AVG_BITS-1:0]   tol_q;
	logic [AVG_BITS-1:0]   blinkw_q;

	// shared unit operands
	logic [DVW-1:0]        acc_q;
	logic [DW-1:0]         sh_q;
	logic [DVW-1:0]        dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DVW-1:0]        acc_nx;
	logic [DW-1:0]         sh_nx;
	step_op_t              step_op;

	// output register
	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;
	logic                     m_tuser_q;

	// decisions
	logic                  gap;
	logic                  start_run;
	logic [AVG_BITS-1:0]   e23;
	logic [AVG_BITS:0]     e24;
	logic [AVG_BITS:0]     a24;
	logic [AVG_BITS:0]     t24;
	logic                  in_tol;
	logic                  last_step;
	logic                  out_free;
	logic [PW-1:0]         prod;
	logic [TEMPO_NUM_BITS-1:0] tempo_quo;
	logic [BEAT_BITS-1:0]  beat_sat;

	assign gap       = elapsed_q > TIME_BITS'(GAP_LIMIT_US);
	assign start_run = (run_q == '0) || gap;
	assign e23       = elapsed_q[AVG_BITS-1:0];
	// |interval - average| < tolerance, split into two one-sided compares
	assign e24       = {1'b0, e23};
	assign a24       = {1'b0, avg_q};
	assign t24       = {1'b0, tol_q};
	assign in_tol    = (e24 < a24 + t24) && (a24 < e24 + t24);
	assign last_step = cnt_q == CNT_W'(1);
	assign out_free  = !m_tvalid_q || m_tready;
	// product plus interval, as left by the multiply
	assign prod      = {acc_q[AVG_BITS-1:0], sh_q[COUNT_BITS-1:0]};
	assign tempo_quo = sh_nx[TEMPO_NUM_BITS-1:0];
	assign beat_sat  = (32'(run_q) > 32'(BPM_MAX)) ? BPM_MAX : BEAT_BITS'(32'(run_q));
	assign step_op   = (state_q == S_MUL) ? STEP_MUL : STEP_DIV;

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign cfg_ready = 1'b1;

	tte_step_unit #(
		.REM_BITS (DVW),
		.SH_BITS  (DW),
		.MUL_BITS (COUNT_BITS)
	) u_step (
		.op      (step_op),
		.acc_in  (acc_q),
		.sh_in   (sh_q),
		.dvs_in  (dvs_q),
		.acc_out (acc_nx),
		.sh_out  (sh_nx)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q) inside
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_ELAP;
				end
			end
			S_ELAP: state_d = S_DECIDE;
			S_DECIDE: begin
				if (!mode_q) begin
					state_d = start_run ? S_DONE : S_DEV;
				end else begin
					state_d = (avg_q < MIN_BLINK_AVG) ? S_DONE : S_MOD;
				end
			end
			S_DEV: state_d = in_tol ? S_MUL : S_DONE;
			S_MUL: begin
				if (last_step) begin
					state_d = S_XFER;
				end
			end
			S_XFER: state_d = S_DIVA;
			S_DIVA: begin
				if (last_step) begin
					state_d = S_TLOAD;
				end
			end
			S_TLOAD: state_d = (avg_q == '0) ? S_DONE : S_TEMPO;
			S_TEMPO, S_MOD: begin
				if (last_step) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOLERANCE_RESET;
			blinkw_q <= BLINK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_TOLERANCE: tol_q    <= cfg_data;
				REG_BLINK:     blinkw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tempo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			avg_q   <= '0;
			run_q   <= '0;
			tempo_q <= '0;
			blink_q <= 1'b0;
			upd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						upd_q <= 1'b0;
					end
				end
				S_DECIDE: begin
					if (!mode_q) begin
						if (start_run) begin
							// first tap, or a tap after a long gap
							run_q  <= COUNT_BITS'(1);
							last_q <= time_q;
						end else if (run_q == COUNT_BITS'(1)) begin
							// second tap seeds the average
							avg_q <= e23;
						end
					end else if (avg_q < MIN_BLINK_AVG) begin
						blink_q <= 1'b0;
					end
				end
				S_DEV: begin
					if (!in_tol) begin
						// out of tempo ends the run
						run_q  <= '0;
						last_q <= time_q;
					end
				end
				S_DIVA: begin
					if (last_step) begin
						avg_q <= sh_nx[AVG_BITS-1:0];
					end
				end
				S_TLOAD: begin
					last_q <= time_q;
					upd_q  <= 1'b1;
					if (run_q != COUNT_MAX) begin
						run_q <= run_q + COUNT_BITS'(1);
					end
					if (avg_q == '0) begin
						tempo_q <= BPM_MAX;
					end
				end
				S_TEMPO: begin
					if (last_step) begin
						tempo_q <= (tempo_quo > TEMPO_NUM_BITS'(BPM_MAX)) ?
							BPM_MAX : tempo_quo[BPM_BITS-1:0];
					end
				end
				S_MOD: begin
					if (last_step) begin
						blink_q <= acc_nx < DVW'(blinkw_q);
					end
				end
				default: ;
			endcase
		end
	end

	// captured transaction and shared unit operands
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				if (s_tvalid) begin
					mode_q <= s_tuser;
					time_q <= s_tdata[TIME_BITS-1:0];
				end
			end
			S_ELAP: elapsed_q <= time_q - last_q;
			S_DECIDE: begin
				// tick: elapsed modulo average
				acc_q <= '0;
				sh_q  <= DW'(elapsed_q) << (DW - TIME_BITS);
				dvs_q <= DVW'(avg_q);
				cnt_q <= CNT_W'(TIME_BITS);
			end
			S_DEV: begin
				// average * run + interval, interval preloaded in the high half
				acc_q <= DVW'(e23);
				sh_q  <= DW'(run_q);
				dvs_q <= DVW'(avg_q);
				cnt_q <= CNT_W'(COUNT_BITS);
			end
			S_MUL, S_DIVA, S_TEMPO, S_MOD: begin
				acc_q <= acc_nx;
				sh_q  <= sh_nx;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_XFER: begin
				// quotient fits 23 bits, so the top bits start as remainder
				acc_q <= DVW'(prod[PW-1:AVG_BITS]);
				sh_q  <= DW'(prod[AVG_BITS-1:0]) << (DW - AVG_BITS);
				dvs_q <= DVW'(run_q) + DVW'(1);
				cnt_q <= CNT_W'(AVG_BITS);
			end
			S_TLOAD: begin
				acc_q <= '0;
				sh_q  <= DW'(TEMPO_NUM) << (DW - TEMPO_NUM_BITS);
				dvs_q <= DVW'(avg_q);
				cnt_q <= CNT_W'(TEMPO_NUM_BITS);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {beat_sat, avg_q, blink_q, tempo_q};
			m_tuser_q <= upd_q;
		end
	end

	// remainder stays below the divisor throughout every divide
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVA || state_q == S_TEMPO || state_q == S_MOD) |-> acc_q < dvs_q)
		else $error("remainder not below divisor");

	// a tempo update always leaves a live run behind
	a_run_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TLOAD |=> run_q != '0)
		else $error("run empty after tempo update");

	// a finished result waits while the previous one is still unread
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && m_tvalid_q && !m_tready) |=> state_q == S_DONE)
		else $error("result overwritten before it was taken");

endmodule

@@ rtl/tte_step_unit.sv @@
// shared shift-add multiply and restoring divide step, one bit per cycle
module tte_step_unit import tte_pkg::*; #(
	parameter int REM_BITS = 23,
	parameter int SH_BITS  = 40,
	parameter int MUL_BITS = 16
) (
	input  step_op_t            op,
	input  logic [REM_BITS-1:0] acc_in,
	input  logic [SH_BITS-1:0]  sh_in,
	input  logic [REM_BITS-1:0] dvs_in,
	output logic [REM_BITS-1:0] acc_out,
	output logic [SH_BITS-1:0]  sh_out
);

	localparam int AW = REM_BITS + 2;

	logic [AW-1:0]       opa;
	logic [AW-1:0]       opb;
	logic [AW-1:0]       sum;
	logic [REM_BITS:0]   r2;
	logic                sub;

	// single adder shared by both operations
	assign sum = opa + (sub ? ~opb : opb) + AW'(sub);
	assign r2  = {acc_in, sh_in[SH_BITS-1]};

	always_comb begin
		opa     = '0;
		opb     = '0;
		sub     = 1'b0;
		acc_out = acc_in;
		sh_out  = sh_in;
		unique case (op)
			STEP_MUL: begin
				// add multiplicand when multiplier lsb is set, then shift right
				opa     = AW'(acc_in);
				opb     = sh_in[0] ? AW'(dvs_in) : '0;
				sub     = 1'b0;
				acc_out = sum[REM_BITS:1];
				sh_out  = {sh_in[SH_BITS-1:MUL_BITS], sum[0], sh_in[MUL_BITS-1:1]};
			end
			STEP_DIV: begin
				// trial subtract, keep the difference when no borrow
				opa = AW'(r2);
				opb = AW'(dvs_in);
				sub = 1'b1;
				if (!sum[AW-1]) begin
					acc_out = sum[REM_BITS-1:0];
				end else begin
					acc_out = r2[REM_BITS-1:0];
				end
				sh_out = {sh_in[SH_BITS-2:0], ~sum[AW-1]};
			end
			default: begin
				acc_out = acc_in;
				sh_out  = sh_in;
			end
		endcase
	end

endmodule

@@ test/tte_tb_pkg.sv @@
// testbench-side codes and widths shared by the checker and the stimulus
package tte_tb_pkg;

	// kind of an input transaction, carried on s_tuser
	typedef enum logic {
		MODE_TAP  = 1'b0,
		MODE_TICK = 1'b1
	} tap_mode_t;

	localparam int STAMP_BITS = 40;

endpackage

@@ test/tap_tempo_checker.sv @@
// checker for the tap tempo estimator: tempo prediction and result comparison
module tap_tempo_checker import tte_pkg::*; import tte_tb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [STAMP_BITS-1:0]    s_tdata,
	input  logic                     s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     m_tuser,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [AVG_BITS-1:0]      cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       results_seen,
	output int                       updates_seen,
	output int                       blinks_seen
);

	typedef struct {
		logic [BPM_BITS-1:0]  bpm;
		logic                 upd;
		logic                 blink;
		logic [AVG_BITS-1:0]  avg;
		logic [BEAT_BITS-1:0] beats;
	} tempo_reading_t;

	// own copy of registers and tempo state
	logic [AVG_BITS-1:0]   tol_cfg;
	logic [AVG_BITS-1:0]   blink_cfg;
	logic [STAMP_BITS-1:0] beat_stamp;
	logic [AVG_BITS-1:0]   mean_interval;
	logic [BEAT_BITS-1:0]  run_beats;
	logic [BPM_BITS-1:0]   tempo_est;
	logic                  lamp_on;

	tempo_reading_t readings_due[$];
	tempo_reading_t want;
	tempo_reading_t got;
	int errors;
	int n_results;
	int n_updates;
	int n_blinks;

	function automatic tempo_reading_t predict_tempo(input tap_mode_t mode,
			input logic [STAMP_BITS-1:0] stamp);
		tempo_reading_t r;
		logic [STAMP_BITS-1:0] elapsed;
		logic [63:0] span, mean, dev, quot;
		r.upd = 1'b0;
		elapsed = stamp - beat_stamp;
		span = 64'(elapsed);
		if (mode == MODE_TAP) begin
			if (run_beats == '0 || span > 64'(GAP_LIMIT_US)) begin
				// first tap of a run, or a restart after a long gap
				run_beats = BEAT_BITS'(1);
				beat_stamp = stamp;
			end else begin
				if (run_beats == 1)
					mean_interval = span[AVG_BITS-1:0];
				mean = 64'(mean_interval);
				dev = (span >= mean) ? span - mean : mean - span;
				if (dev < 64'(tol_cfg)) begin
					mean = (mean * 64'(run_beats) + span) / (64'(run_beats) + 64'd1);
					mean_interval = mean[AVG_BITS-1:0];
					beat_stamp = stamp;
					if (mean_interval == '0) begin
						tempo_est = BPM_MAX;
					end else begin
						quot = 64'(TEMPO_NUM) / 64'(mean_interval);
						tempo_est = (quot > 64'(BPM_MAX)) ? BPM_MAX : quot[BPM_BITS-1:0];
					end
					r.upd = 1'b1;
					if (run_beats != '1)
						run_beats = run_beats + 1'b1;
				end else begin
					run_beats = '0;
					beat_stamp = stamp;
				end
			end
		end else begin
			if (mean_interval < MIN_BLINK_AVG)
				lamp_on = 1'b0;
			else
				lamp_on = (span % 64'(mean_interval)) < 64'(blink_cfg);
		end
		r.bpm   = tempo_est;
		r.blink = lamp_on;
		r.avg   = mean_interval;
		r.beats = run_beats;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_cfg       = TOLERANCE_RESET;
			blink_cfg     = BLINK_RESET;
			beat_stamp    = '0;
			mean_interval = '0;
			run_beats     = '0;
			tempo_est     = '0;
			lamp_on       = 1'b0;
			readings_due.delete();
			errors        = 0;
			n_results     = 0;
			n_updates     = 0;
			n_blinks      = 0;
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			updates_seen <= 0;
			blinks_seen  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					REG_TOLERANCE: tol_cfg = cfg_data;
					REG_BLINK:     blink_cfg = cfg_data;
					default: ;
				endcase
			end
			// results first: no result can belong to a same-edge input
			if (m_tvalid && m_tready) begin
				got.bpm   = m_tdata[BPM_BITS-1:0];
				got.blink = m_tdata[BPM_BITS];
				got.avg   = m_tdata[BPM_BITS+1 +: AVG_BITS];
				got.beats = m_tdata[BPM_BITS+1+AVG_BITS +: BEAT_BITS];
				got.upd   = m_tuser;
				n_results++;
				if (got.upd === 1'b1)
					n_updates++;
				if (got.blink === 1'b1)
					n_blinks++;
				if (readings_due.size() == 0) begin
					$error("output transaction with no input transaction outstanding");
					errors++;
				end else begin
					want = readings_due.pop_front();
					check_field("bpm_hundredths", 64'(want.bpm), 64'(got.bpm));
					check_field("bpm_updated", 64'(want.upd), 64'(got.upd));
					check_field("blink_on", 64'(want.blink), 64'(got.blink));
					check_field("average_us", 64'(want.avg), 64'(got.avg));
					check_field("beat_count", 64'(want.beats), 64'(got.beats));
				end
			end
			if (s_tvalid && s_tready)
				readings_due.push_back(predict_tempo(tap_mode_t'(s_tuser), s_tdata));
			fail_count   <= errors;
			pending      <= readings_due.size();
			results_seen <= n_results;
			updates_seen <= n_updates;
			blinks_seen  <= n_blinks;
		end
	end

endmodule

@@ test/tap_tempo_estimator_tb.sv @@
// testbench top for the tap tempo estimator: stimulus, flow control and verdict
module tap_tempo_estimator_tb;
	import tte_pkg::*;
	import tte_tb_pkg::*;

	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int WATCHDOG_LIMIT  = 4000;  // well above the longest quiet stretch of the stimulus
	localparam int DRAIN_CYCLES    = 100;   // beyond the slowest in-tempo tap

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [STAMP_BITS-1:0]    s_tdata;
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [AVG_BITS-1:0]      cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int updates_seen;
	int blinks_seen;

	// stimulus bookkeeping
	int                    items_sent = 0;
	logic                  no_gaps = 1'b0;
	logic [STAMP_BITS-1:0] beat_t;
	logic [AVG_BITS-1:0]   cur_tol;
	logic [AVG_BITS-1:0]   tol_set   [N_PHASES];
	logic [AVG_BITS-1:0]   blink_set [N_PHASES];
	int                    sink_hold = 0;
	int                    quiet_cycles = 0;

	tap_tempo_estimator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	tap_tempo_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.updates_seen (updates_seen),
		.blinks_seen  (blinks_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side flow control: short and long stalls, plus long stretches of
	// steady ready so back-to-back results also get through
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
		end else begin
			case ($urandom_range(0, 19)) inside
				[0:9]: begin
					m_tready  <= 1'b1;
					sink_hold <= $urandom_range(0, 8);
				end
				10, 11: begin
					m_tready  <= 1'b1;
					sink_hold <= $urandom_range(50, 400);
				end
				19: begin
					m_tready  <= 1'b0;
					sink_hold <= $urandom_range(20, 150);
				end
				default: begin
					m_tready  <= 1'b0;
					sink_hold <= $urandom_range(0, 4);
				end
			endcase
		end
	end

	// watchdog on cycles in which no transaction of any channel completes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** tap_tempo_estimator: FAILED **");
			$finish;
		end
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int source_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	// nominal beat interval: tiny (reaching below the blink floor), fast (tempo
	// mostly saturates), ordinary, and slow up to the gap limit
	function automatic int unsigned pick_period();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(100, 5000);
			1:       return $urandom_range(5000, 100000);
			2:       return $urandom_range(100000, 2000000);
			default: return $urandom_range(2000000, 5000000);
		endcase
	endfunction

	// one input transaction; valid is only lowered when a gap follows, so it
	// never drops and rises within one time step
	task automatic send_item(input tap_mode_t mode, input logic [STAMP_BITS-1:0] stamp);
		int gap;
		gap = source_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= stamp;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// stop the source and wait until every result is back; pending is a
	// registered count, so reading it after the next edge is race free
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [AVG_BITS-1:0] tol, input logic [AVG_BITS-1:0] blink);
		cfg_valid <= 1'b1;
		cfg_addr  <= REG_TOLERANCE;
		cfg_data  <= tol;
		do @(posedge clk); while (!cfg_ready);
		cfg_addr  <= REG_BLINK;
		cfg_data  <= blink;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// hand-picked sequence under the reset register values
	task automatic run_directed();
		send_item(MODE_TICK, 40'd0);                 // tick with no average yet
		send_item(MODE_TAP, 40'd1000000);            // run starts
		send_item(MODE_TAP, 40'd1000000);            // zero interval: average zero, tempo saturates
		send_item(MODE_TICK, 40'd1000500);           // average below the blink floor
		send_item(MODE_TAP, 40'd1500000);            // out of tolerance, run ends
		send_item(MODE_TAP, 40'd2000000);
		send_item(MODE_TAP, 40'd2500000);            // seeds the average
		send_item(MODE_TAP, 40'd3000050);            // in tempo, running mean
		send_item(MODE_TICK, 40'd3000100);           // inside the on-phase
		send_item(MODE_TICK, 40'd3300000);           // outside it
		send_item(MODE_TICK, 40'd3500076);           // one period on, phase wraps round
		send_item(MODE_TAP, 40'd8000051);            // just over the gap limit: restart
		send_item(MODE_TAP, 40'd8050051);            // fast tempo, saturated
		send_item(MODE_TAP, 40'd8100040);
		send_item(MODE_TICK, 40'd12345);             // timestamp running backwards
		send_item(MODE_TAP, 40'hFF_FFFF_FF9C);       // huge interval: restart near the top
		send_item(MODE_TAP, 40'd150);                // timestamp wraps, small interval
		send_item(MODE_TICK, 40'd300);
		send_item(MODE_TAP, 40'd1000000);            // run ends
		send_item(MODE_TAP, 40'd2000000);
		send_item(MODE_TAP, 40'd7000000);            // exactly the gap limit: largest average
		send_item(MODE_TICK, 40'd7000010);
		send_item(MODE_TICK, 40'd11999999);
		send_item(MODE_TAP, 40'd12000001);           // restart keeps the old average
		send_item(MODE_TICK, 40'd12000050);
		beat_t = 40'd12000001;
	endtask

	// one random stretch: mostly runs of taps near a steady period with
	// ticks in between, the rest noise, long gaps and timestamps near wrap
	task automatic play_segment(input logic [AVG_BITS-1:0] tol);
		int unsigned kind, period, taps, jmax;
		longint jit;
		logic [STAMP_BITS-1:0] stamp;
		kind = $urandom_range(0, 9);
		no_gaps = ($urandom_range(0, 3) == 0);
		if (kind <= 6) begin
			period = pick_period();
			taps = $urandom_range(2, 12);
			// a fifth of the runs jitter wider than the tolerance
			jmax = ($urandom_range(0, 4) == 0) ? tol * 2 : tol / 2;
			for (int i = 0; i < taps; i++) begin
				jit = longint'($urandom_range(0, 2 * jmax)) - longint'(jmax);
				if (i == 0)
					beat_t = beat_t + 40'($urandom_range(0, 7000000));
				else
					beat_t = beat_t + 40'(longint'(period) + jit);
				send_item(MODE_TAP, beat_t);
				repeat ($urandom_range(0, 2))
					send_item(MODE_TICK, beat_t + 40'($urandom_range(0, 3 * period)));
			end
		end else if (kind == 7) begin
			stamp = beat_t;
			repeat ($urandom_range(1, 4)) begin
				stamp = 40'({$urandom, $urandom});
				send_item(tap_mode_t'($urandom_range(0, 1)), stamp);
			end
			beat_t = stamp;
		end else if (kind == 8) begin
			beat_t = beat_t + 40'($urandom_range(5000001, 60000000));
			send_item(MODE_TAP, beat_t);
		end else begin
			beat_t = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 12000000));
			send_item(MODE_TAP, beat_t);
			send_item(MODE_TICK, beat_t + 40'($urandom_range(0, 20000000)));
		end
	endtask

	initial begin
		int phase_start;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr  = REG_TOLERANCE;
		cfg_data  = '0;
		beat_t    = '0;

		// register settings per phase: reset values, both extremes, an
		// exact-match tolerance, then random ones
		tol_set[0] = TOLERANCE_RESET;  blink_set[0] = BLINK_RESET;
		tol_set[1] = 23'd0;            blink_set[1] = 23'd0;
		tol_set[2] = 23'd5000000;      blink_set[2] = 23'd5000000;
		tol_set[3] = 23'd1;            blink_set[3] = 23'd1000;
		for (int p = 4; p < N_PHASES; p++) begin
			tol_set[p]   = 23'($urandom_range(1000, 600000));
			blink_set[p] = 23'($urandom_range(0, 5000000));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 0) begin
				run_directed();
			end else begin
				settle();
				write_regs(tol_set[p], blink_set[p]);
			end
			cur_tol = tol_set[p];
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE)
				play_segment(cur_tol);
		end

		// drain, then allow for any stray result
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tap/tick transactions: %0d sent, %0d results over %0d register settings",
			items_sent, results_seen, N_PHASES);
		$display("tempo updates: %0d, results with blink on: %0d", updates_seen, blinks_seen);
		if (fail_count == 0)
			$display("** tap_tempo_estimator: PASSED **");
		else
			$display("** tap_tempo_estimator: FAILED **");
		$finish;
	end

endmodule
